[src/ootx_bit_deframer_macros.svh]
// ============================================================================
// ootx_bit_deframer_macros.svh - assertion macros
// Concurrent assertion wrappers for the OOTX bit deframer. The bodies are
// empty when SYNTHESIS is defined.
// ============================================================================
`ifndef OOTX_BIT_DEFRAMER_MACROS_SVH
`define OOTX_BIT_DEFRAMER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, off during reset
`define OOTXD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on clk, off during reset
`define OOTXD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define OOTXD_ASSERT_NOW(label, ante, cons)
`define OOTXD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[src/ootxd_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// ootxd_pkg - OOTX deframer shared definitions
// Context layout, phase and event codes, and the CRC-32 / byte-swap helpers.
// ============================================================================
package ootxd_pkg;

    // Deframer phases
    localparam logic [1:0] PH_PREAMBLE = 2'd0;
    localparam logic [1:0] PH_LENGTH   = 2'd1;
    localparam logic [1:0] PH_PAYLOAD  = 2'd2;
    localparam logic [1:0] PH_CHECKSUM = 2'd3;

    // Event codes
    localparam logic [1:0] EV_BYTE     = 2'd0;
    localparam logic [1:0] EV_CRC_GOOD = 2'd1;
    localparam logic [1:0] EV_CRC_BAD  = 2'd2;
    localparam logic [1:0] EV_TOO_LONG = 2'd3;

    localparam logic [4:0]  PREAMBLE_ZEROS_RESET = 5'd17;
    localparam logic [4:0]  ZERO_RUN_MAX         = 5'd31;
    localparam logic [4:0]  BITS_PER_WORD        = 5'd16;
    localparam logic [4:0]  BITS_PER_BYTE        = 5'd8;
    localparam logic [6:0]  CRC_BYTES            = 7'd4;
    localparam logic [31:0] CRC_INIT             = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY             = 32'hEDB8_8320;

    // Per-channel deframer context
    typedef struct packed {
        logic [1:0]  phase;
        logic [4:0]  zero_run;
        logic [15:0] length_word;
        logic        pad_flag;
        logic [4:0]  bit_counter;
        logic [6:0]  byte_position;
        logic [7:0]  byte_shift;
        logic [31:0] running_crc;
        logic [31:0] received_crc;
    } ctx_t;

    localparam ctx_t CTX_RESET = '{
        phase:         PH_PREAMBLE,
        zero_run:      5'd0,
        length_word:   16'd0,
        pad_flag:      1'b0,
        bit_counter:   5'd0,
        byte_position: 7'd0,
        byte_shift:    8'd0,
        running_crc:   CRC_INIT,
        received_crc:  32'd0
    };

    // Result of one step, channel added by the top level
    typedef struct packed {
        logic        has_result;
        logic [1:0]  kind;
        logic [5:0]  byte_index;
        logic [7:0]  byte_value;
        logic [15:0] frame_length;
        logic [31:0] frame_time;
    } step_res_t;

    // Reflected CRC-32, one byte
    function automatic logic [31:0] crc32_add_byte(input logic [31:0] crc,
                                                   input logic [7:0] data);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

    function automatic logic [15:0] flip16(input logic [15:0] v);
        return {v[7:0], v[15:8]};
    endfunction

    function automatic logic [31:0] flip32(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

[src/ootx_bit_deframer.sv]
`timescale 1ns / 1ps
// ============================================================================
// ootx_bit_deframer - multi-channel OOTX bit deframer
// Per-channel frame recovery with payload byte and CRC-32 events.
// ============================================================================
// One received bit is taken per clock on the input channel, except while
// in_ready is held low by a stall. A bit moves through an input register
// and its event (if any) then lands in the output register. The rate is set
// by the per-channel context update: the context of a channel is read and
// updated while the bit is in the input register and written back as it
// leaves, so consecutive bits of one channel never wait on each other.
// in_ready follows out_ready combinationally when the bit in the input
// register produces an event and the output register is full. Bits on a
// channel at or above CHANNELS are taken and dropped.
// preamble_zeros may only be written while no bit is in flight.
`include "ootx_bit_deframer_macros.svh"

module ootx_bit_deframer
    import ootxd_pkg::*;
#(
    parameter int CHANNELS    = 2,
    parameter int MAX_PAYLOAD = 64
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  channel,
    input  logic        bit_value,
    input  logic [31:0] time_stamp,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  event_kind,
    output logic [1:0]  source_channel,
    output logic [5:0]  byte_index,
    output logic [7:0]  byte_value,
    output logic [15:0] frame_length,
    output logic [31:0] frame_time
);

    localparam int          CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [2:0]  CH_LIMIT   = 3'(CHANNELS);

    ctx_t        ctx_reg [CHANNELS];
    logic [4:0]  preamble_zeros_reg;

    logic        stage_valid_reg;
    logic [1:0]  stage_channel_reg;
    logic        stage_bit_reg;
    logic [31:0] stage_time_reg;

    logic        out_valid_reg;
    logic [1:0]  out_kind_reg;
    logic [1:0]  out_channel_reg;
    logic [5:0]  out_index_reg;
    logic [7:0]  out_value_reg;
    logic [15:0] out_length_reg;
    logic [31:0] out_time_reg;

    logic        in_transfer;
    logic        in_range;
    logic        out_free;
    logic        stage_advance;
    ctx_t        ctx_cur;
    ctx_t        ctx_next;
    step_res_t   step_res;

    // Handshake
    assign in_range      = ({1'b0, channel} < CH_LIMIT);
    assign out_free      = !out_valid_reg || out_ready;
    assign stage_advance = stage_valid_reg && (!step_res.has_result || out_free);
    assign in_ready      = !stage_valid_reg || stage_advance;
    assign in_transfer   = in_valid && in_ready;

    // Context of the channel in the input register
    assign ctx_cur = ctx_reg[stage_channel_reg[CH_W-1:0]];

    ootxd_step #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_step (
        .ctx_in         (ctx_cur),
        .bit_value      (stage_bit_reg),
        .time_stamp     (stage_time_reg),
        .preamble_zeros (preamble_zeros_reg),
        .ctx_out        (ctx_next),
        .res            (step_res)
    );

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            preamble_zeros_reg <= PREAMBLE_ZEROS_RESET;
        end else if (cfg_wr_en) begin
            preamble_zeros_reg <= cfg_wr_data;
        end
    end

    // Context store, written back as the bit leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                ctx_reg[i] <= CTX_RESET;
            end
        end else if (stage_advance) begin
            ctx_reg[stage_channel_reg[CH_W-1:0]] <= ctx_next;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            stage_valid_reg <= 1'b0;
        end else if (in_transfer && in_range) begin
            stage_valid_reg <= 1'b1;
        end else if (stage_advance) begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_transfer && in_range) begin
            stage_channel_reg <= channel;
            stage_bit_reg     <= bit_value;
            stage_time_reg    <= time_stamp;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (stage_advance && step_res.has_result) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_advance && step_res.has_result) begin
            out_kind_reg    <= step_res.kind;
            out_channel_reg <= stage_channel_reg;
            out_index_reg   <= step_res.byte_index;
            out_value_reg   <= step_res.byte_value;
            out_length_reg  <= step_res.frame_length;
            out_time_reg    <= step_res.frame_time;
        end
    end

    assign out_valid      = out_valid_reg;
    assign event_kind     = out_kind_reg;
    assign source_channel = out_channel_reg;
    assign byte_index     = out_index_reg;
    assign byte_value     = out_value_reg;
    assign frame_length   = out_length_reg;
    assign frame_time     = out_time_reg;

    // Checks
    `OOTXD_ASSERT_NEXT(a_stall_holds_bit,
        stage_valid_reg && step_res.has_result && !out_free,
        stage_valid_reg && $stable(stage_time_reg) && $stable(stage_channel_reg))
    `OOTXD_ASSERT_NEXT(a_ignored_channel_dropped,
        in_transfer && !in_range,
        !stage_valid_reg)
    `OOTXD_ASSERT_NOW(a_byte_event_clean,
        out_valid_reg && (out_kind_reg == EV_BYTE),
        (out_length_reg == 16'd0) && (out_time_reg == 32'd0))

endmodule

[src/ootxd_step.sv]
`timescale 1ns / 1ps
// ============================================================================
// ootxd_step - deframer context update
// Combinational next-context and event logic for one received bit.
// ============================================================================
module ootxd_step
    import ootxd_pkg::*;
#(
    parameter int MAX_PAYLOAD = 64
)
(
    input  ctx_t        ctx_in,
    input  logic        bit_value,
    input  logic [31:0] time_stamp,
    input  logic [4:0]  preamble_zeros,
    output ctx_t        ctx_out,
    output step_res_t   res
);

    localparam logic [16:0] MAX_TOTAL = 17'(MAX_PAYLOAD);

    logic [16:0] total;
    logic [15:0] len_swapped;
    logic [16:0] len_total;
    logic [6:0]  pos_inc;
    logic        boundary;
    logic        wide_cnt;
    logic [7:0]  shift_next;
    logic [4:0]  cnt_inc;
    logic [31:0] crc_calc;

    always_comb
    begin
        total       = {1'b0, ctx_in.length_word} + {16'd0, ctx_in.pad_flag};
        len_swapped = flip16(ctx_in.length_word);
        len_total   = {1'b0, len_swapped} + {16'd0, len_swapped[0]};
        pos_inc     = ctx_in.byte_position + 7'd1;
        wide_cnt    = (ctx_in.bit_counter >= BITS_PER_WORD);
        boundary    = (ctx_in.bit_counter == BITS_PER_BYTE) || wide_cnt;
        shift_next  = {ctx_in.byte_shift[6:0], bit_value};
        cnt_inc     = ctx_in.bit_counter + 5'd1;
        crc_calc    = ~ctx_in.running_crc;
    end

    always_comb
    begin
        ctx_out = ctx_in;
        res     = '0;

        if (bit_value && (ctx_in.zero_run >= preamble_zeros)) begin
            // preamble seen: restart in the length phase
            ctx_out.phase         = PH_LENGTH;
            ctx_out.length_word   = 16'd0;
            ctx_out.byte_position = 7'd0;
            ctx_out.bit_counter   = 5'd0;
            ctx_out.zero_run      = 5'd0;
        end else begin
            // zero run tracking, saturating
            if (bit_value) begin
                ctx_out.zero_run = 5'd0;
            end else if (ctx_in.zero_run < ZERO_RUN_MAX) begin
                ctx_out.zero_run = ctx_in.zero_run + 5'd1;
            end

            case (ctx_in.phase)
                PH_LENGTH:
                begin
                    if (wide_cnt) begin
                        // sync bit after the length word
                        ctx_out.length_word   = len_swapped;
                        ctx_out.pad_flag      = len_swapped[0];
                        ctx_out.bit_counter   = 5'd0;
                        ctx_out.byte_position = 7'd0;
                        ctx_out.byte_shift    = 8'd0;
                        ctx_out.received_crc  = 32'd0;
                        ctx_out.running_crc   = CRC_INIT;
                        if (len_total > MAX_TOTAL) begin
                            ctx_out.phase    = PH_PREAMBLE;
                            res.has_result   = 1'b1;
                            res.kind         = EV_TOO_LONG;
                            res.frame_length = len_swapped;
                            res.frame_time   = time_stamp;
                        end else if (len_total == 17'd0) begin
                            ctx_out.phase = PH_CHECKSUM;
                        end else begin
                            ctx_out.phase = PH_PAYLOAD;
                        end
                    end else begin
                        ctx_out.length_word = ctx_in.length_word |
                            ({15'd0, bit_value} << (4'd15 - ctx_in.bit_counter[3:0]));
                        ctx_out.bit_counter = cnt_inc;
                    end
                end

                PH_PAYLOAD:
                begin
                    if (boundary && ({10'd0, pos_inc} >= total)) begin
                        // last payload byte done
                        ctx_out.byte_position = pos_inc;
                        ctx_out.phase         = PH_CHECKSUM;
                        ctx_out.bit_counter   = 5'd0;
                        ctx_out.byte_position = 7'd0;
                        ctx_out.received_crc  = 32'd0;
                    end else if (wide_cnt) begin
                        // sync bit
                        ctx_out.byte_position = pos_inc;
                        ctx_out.bit_counter   = 5'd0;
                    end else begin
                        if (boundary) begin
                            ctx_out.byte_position = pos_inc;
                        end
                        ctx_out.byte_shift  = shift_next;
                        ctx_out.bit_counter = cnt_inc;
                        // byte completion never falls on a boundary bit
                        if (cnt_inc[2:0] == 3'd0) begin
                            ctx_out.byte_shift = 8'd0;
                            if ({9'd0, ctx_in.byte_position} < ctx_in.length_word) begin
                                ctx_out.running_crc = crc32_add_byte(ctx_in.running_crc,
                                                                     shift_next);
                                res.has_result = 1'b1;
                                res.kind       = EV_BYTE;
                                res.byte_index = ctx_in.byte_position[5:0];
                                res.byte_value = shift_next;
                            end
                        end
                    end
                end

                PH_CHECKSUM:
                begin
                    if (boundary && (pos_inc >= CRC_BYTES)) begin
                        // frame end: compare CRC
                        ctx_out.phase         = PH_PREAMBLE;
                        ctx_out.byte_position = 7'd0;
                        ctx_out.bit_counter   = 5'd0;
                        ctx_out.zero_run      = 5'd0;
                        ctx_out.length_word   = 16'd0;
                        res.has_result        = 1'b1;
                        res.kind              = (crc_calc == flip32(ctx_in.received_crc)) ?
                                                EV_CRC_GOOD : EV_CRC_BAD;
                        res.frame_length      = ctx_in.length_word;
                        res.frame_time        = time_stamp;
                    end else if (wide_cnt) begin
                        ctx_out.byte_position = pos_inc;
                        ctx_out.bit_counter   = 5'd0;
                    end else begin
                        if (boundary) begin
                            ctx_out.byte_position = pos_inc;
                        end
                        ctx_out.received_crc = {ctx_in.received_crc[30:0], bit_value};
                        ctx_out.bit_counter  = cnt_inc;
                    end
                end

                default:
                begin
                    // waiting for preamble: only the zero run moves
                end
            endcase
        end
    end

endmodule
